@@ sv/simd_twister_random_generator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the twister random generator
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SIMD_TWISTER_RANDOM_GENERATOR_MACROS_SVH
`define SIMD_TWISTER_RANDOM_GENERATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define STG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define STG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define STG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/stg_pkg.sv @@
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types and constants of the twister random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

  // item operation codes
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // seed recurrence multiplier
  localparam logic [31:0] INIT_MULT = 32'd1812433253;

  // per-word mask of the recursion, element 0 in the low word
  localparam logic [127:0] MIX_MASK = {32'hedfefffd, 32'hcbfff7fe,
                                       32'hffdff7fb, 32'hfffef7f9};

  // shift in bits of the whole-vector terms, one byte
  localparam int VEC_SHIFT = 8;

  // read address select of the store
  typedef enum logic [1:0] {
    RD_WORD,
    RD_PRE,
    RD_REGEN
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    rd_sel_t rd_sel;
    logic    seed_load;
    logic    seed_mul;
    logic    seed_add;
    logic    regen_load;
    logic    regen_step;
    logic    idx_clear;
    logic    deliver;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_wrap;
    logic seeded;
    logic seed_last;
    logic regen_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/stg_ifs.sv @@
// ----------------------------------------------------------------------------
// stg_in_if / stg_out_if
// Valid/ready channels of the twister random generator.
// ----------------------------------------------------------------------------
`default_nettype none

interface stg_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] seed;

  modport source (output valid, output op, output seed, input ready);
  modport sink   (input valid, input op, input seed, output ready);
endinterface

interface stg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

@@ sv/stg_ctrl.sv @@
// ----------------------------------------------------------------------------
// stg_ctrl
// Sequencer for seeding, regeneration and word delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_ctrl
  import stg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_op,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMUL,
    S_SADD,
    S_PRE,
    S_LOAD,
    S_RREAD,
    S_RCALC,
    S_RDW,
    S_DLV
  } state_t;

  state_t state_r, state_nxt;

  // command decode and next state
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = RD_WORD;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_SEED) begin
            cmd.seed_load = 1'b1;
            state_nxt     = S_SMUL;
          end else if (!stat.idx_wrap) begin
            state_nxt = S_DLV;
          end else if (stat.seeded) begin
            state_nxt = S_PRE;
          end else begin
            // a never-seeded store reads as zero: just restart the index
            cmd.idx_clear = 1'b1;
            state_nxt     = S_DLV;
          end
        end
      end
      S_SMUL: begin
        cmd.seed_mul = 1'b1;
        state_nxt    = S_SADD;
      end
      S_SADD: begin
        cmd.seed_add = 1'b1;
        state_nxt    = stat.seed_last ? S_IDLE : S_SMUL;
      end
      S_PRE: begin
        cmd.rd_sel = RD_PRE;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.regen_load = 1'b1;
        state_nxt      = S_RREAD;
      end
      S_RREAD: begin
        cmd.rd_sel = RD_REGEN;
        state_nxt  = S_RCALC;
      end
      S_RCALC: begin
        cmd.regen_step = 1'b1;
        if (stat.regen_last) begin
          cmd.idx_clear = 1'b1;
          state_nxt     = S_RDW;
        end else begin
          state_nxt = S_RREAD;
        end
      end
      S_RDW: begin
        state_nxt = S_DLV;
      end
      S_DLV: begin
        if (stat.out_free) begin
          cmd.deliver = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/stg_dp.sv @@
// ----------------------------------------------------------------------------
// stg_dp
// Vector store, seed recurrence, recursion unit and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_dp
  import stg_pkg::*;
#(
  parameter int VECTORS         = 156,
  parameter int PICK_OFFSET     = 4,
  parameter int WORD_LEFT_SHIFT = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic [31:0] in_seed,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [31:0]      out_word
);

  localparam int TOTAL = 4 * VECTORS;
  localparam int ROWW  = $clog2(VECTORS);
  localparam int IDXW  = $clog2(TOTAL + 1);
  localparam int WCW   = $clog2(TOTAL);
  localparam logic [IDXW-3:0] VEC_ROWS = (IDXW-2)'(VECTORS);

  // store: one row per 128-bit vector, element 0 in the low word
  logic [127:0] mem [VECTORS];

  logic [IDXW-1:0] index_r;
  logic            seeded_r;
  logic [31:0]     p_r;
  logic [31:0]     prod_r;
  logic [WCW-1:0]  wcnt_r;
  logic [127:0]    acc_r;
  logic [ROWW-1:0] vec_r;
  logic [ROWW-1:0] pick_r;
  logic [127:0]    c_r;
  logic [127:0]    d_r;
  logic [127:0]    rd_a_r;
  logic [127:0]    rd_b_r;
  logic            out_valid_r;
  logic [31:0]     out_word_r;

  logic [IDXW-3:0] word_row;
  logic [ROWW-1:0] addr_a;
  logic [ROWW-1:0] addr_b;
  logic [31:0]     seed_mix;
  logic [31:0]     prod_lo;
  logic [31:0]     seed_word;
  logic [127:0]    seed_row;
  logic [127:0]    b_term;
  logic [127:0]    d_term;
  logic [127:0]    regen_res;
  logic            mem_we;
  logic [ROWW-1:0] mem_waddr;
  logic [127:0]    mem_wdata;

  // read addresses
  assign word_row = index_r[IDXW-1:2];

  always_comb begin
    case (cmd.rd_sel)
      RD_WORD: begin
        addr_a = (word_row < VEC_ROWS) ? ROWW'(word_row) : '0;
        addr_b = '0;
      end
      RD_PRE: begin
        addr_a = ROWW'(VECTORS - 2);
        addr_b = ROWW'(VECTORS - 1);
      end
      RD_REGEN: begin
        addr_a = vec_r;
        addr_b = pick_r;
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  // seed recurrence: the multiply is registered in prod_r, then the word index is added
  assign seed_mix  = p_r ^ (p_r >> 30);
  assign prod_lo   = INIT_MULT * seed_mix;
  assign seed_word = prod_r + 32'(wcnt_r);

  always_comb begin
    seed_row = acc_r;
    seed_row[wcnt_r[1:0]*32 +: 32] = seed_word;
  end

  // recursion on one vector
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      b_term[k*32 +: 32] = rd_b_r[k*32 +: 32] >> 1;
      d_term[k*32 +: 32] = d_r[k*32 +: 32] << WORD_LEFT_SHIFT;
    end
    regen_res = rd_a_r ^ (rd_a_r << VEC_SHIFT) ^ (b_term & MIX_MASK)
              ^ (c_r >> VEC_SHIFT) ^ d_term;
  end

  // store write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = vec_r;
    mem_wdata = regen_res;
    if (cmd.regen_step) begin
      mem_we = 1'b1;
    end else if (cmd.seed_add && (wcnt_r[1:0] == 2'd3)) begin
      mem_we    = 1'b1;
      mem_waddr = wcnt_r[WCW-1:2];
      mem_wdata = seed_row;
    end
  end

  // store with registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      p_r         <= in_seed;
      acc_r[31:0] <= in_seed;
      wcnt_r      <= WCW'(1);
    end
    if (cmd.seed_mul) begin
      prod_r <= prod_lo;
    end
    if (cmd.seed_add) begin
      p_r    <= seed_word;
      acc_r  <= seed_row;
      wcnt_r <= wcnt_r + WCW'(1);
    end
    if (cmd.regen_load) begin
      c_r    <= rd_a_r;
      d_r    <= rd_b_r;
      vec_r  <= '0;
      // partner offset folded into the store
      pick_r <= ROWW'(PICK_OFFSET % VECTORS);
    end
    if (cmd.regen_step) begin
      c_r    <= d_r;
      d_r    <= regen_res;
      vec_r  <= vec_r + ROWW'(1);
      pick_r <= (pick_r == ROWW'(VECTORS - 1)) ? '0 : pick_r + ROWW'(1);
    end
    if (cmd.deliver) begin
      // words read as zero until the first seed
      out_word_r <= seeded_r ? rd_a_r[index_r[1:0]*32 +: 32] : '0;
    end
  end

  // read index, seeded flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r     <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.seed_add && stat.seed_last) begin
        index_r  <= IDXW'(TOTAL);
        seeded_r <= 1'b1;
      end else if (cmd.idx_clear) begin
        index_r <= '0;
      end else if (cmd.deliver) begin
        index_r <= index_r + IDXW'(1);
      end
      if (cmd.deliver) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // status
  assign stat.idx_wrap   = (index_r >= IDXW'(TOTAL));
  assign stat.seeded     = seeded_r;
  assign stat.seed_last  = (wcnt_r == WCW'(TOTAL - 1));
  assign stat.regen_last = (vec_r == ROWW'(VECTORS - 1));
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

@@ sv/simd_twister_random_generator.sv @@
// ----------------------------------------------------------------------------
// simd_twister_random_generator
// Twister generator over VECTORS 128-bit vectors, one 32-bit word per item.
// ----------------------------------------------------------------------------
//  channel | dir | payload             | note
//  in_ch   | in  | op, seed            | op 0 seeds, op 1 requests a word
//  out_ch  | out | random_word         | one word per op 1 item
//
//  A next item is accepted with the store read, then the output is loaded.
//  When the store is used up, regeneration first reads the last two vectors, then
//  reads and rewrites each vector through the store's read/write ports.
//  A seed item takes the seed as word 0, then one multiply and one add per word.
//  Reset is synchronous; the store itself is not cleared, reads before the
//  first seed return zero. A stalled output holds the next item at the last step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "simd_twister_random_generator_macros.svh"

module simd_twister_random_generator
  import stg_pkg::*;
#(
  parameter int VECTORS         = 156,
  parameter int PICK_OFFSET     = 4,
  parameter int WORD_LEFT_SHIFT = 20
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  stg_in_if.sink     in_ch,
  stg_out_if.source  out_ch
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;

  // sequencer
  stg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store and arithmetic
  stg_dp #(
    .VECTORS         (VECTORS),
    .PICK_OFFSET     (PICK_OFFSET),
    .WORD_LEFT_SHIFT (WORD_LEFT_SHIFT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_seed   (in_ch.seed),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_word  (out_ch.random_word)
  );

  // checks
  `STG_ASSERT_NXT(a_seed_busy, clk, rst_n, in_acc && (in_ch.op == OP_SEED), !in_ch.ready, "seed item did not hold off input")
  `STG_ASSERT_NXT(a_deliver_shows, clk, rst_n, cmd.deliver, out_ch.valid, "delivered word not shown")
  `STG_ASSERT_IMP(a_seeded_sticky, clk, rst_n, 1'b1, !$fell(stat.seeded), "seeded flag dropped")
  `STG_ASSERT_IMP(a_unseeded_zero, clk, rst_n, out_ch.valid && !stat.seeded, out_ch.random_word == 32'd0, "nonzero word before first seed")

endmodule

`default_nettype wire

@@ verif/tb_simd_twister_random_generator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_simd_twister_random_generator
// Self-checking bench for the 128-bit-vector twister generator. A local
// predictor keeps its own copy of the vector store and read index. It works
// out every requested word, and each output item is checked in order. The
// stimulus covers:
//   - reads of the store before any seed, through one read index wrap
//   - seed extremes and a reseed
//   - long output back-pressure
//   - a random stream of seed/next runs under four idling phases
// ----------------------------------------------------------------------------

module tb_simd_twister_random_generator;
  import stg_pkg::*;

  localparam int VECTORS         = 156;
  localparam int PICK_OFFSET     = 4;
  localparam int WORD_LEFT_SHIFT = 20;
  localparam int TOTAL_WORDS     = 4 * VECTORS;
  localparam int SEED_CYCLES     = 2 * (TOTAL_WORDS - 1) + 1;
  localparam int LIMIT_CYCLES    = 900000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic clk;
  logic rst_n;

  stg_in_if  in_ch ();
  stg_out_if out_ch ();

  simd_twister_random_generator #(
    .VECTORS         (VECTORS),
    .PICK_OFFSET     (PICK_OFFSET),
    .WORD_LEFT_SHIFT (WORD_LEFT_SHIFT)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic [127:0] twist_store [VECTORS];
  int unsigned  word_idx;

  // words still owed by the block, oldest first
  logic [31:0]  pending_words [$];

  int fail_count;
  int items_sent;
  int seeds_sent;
  int words_checked;
  int regen_count;
  int tx_gap_pct;
  int rx_stall_pct;
  int rx_hold_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  // multiplicative fill of all words from the seed
  function automatic void load_seed(input logic [31:0] s);
    logic [31:0] w;
    logic [31:0] p;
    int          i;
    w = s;
    twist_store[0][31:0] = w;
    for (i = 1; i < TOTAL_WORDS; i++) begin
      p = w;
      w = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
      twist_store[i / 4][32 * (i % 4) +: 32] = w;
    end
    word_idx = TOTAL_WORDS;
  endfunction

  // in-place pass over all vectors; the partner past the end is already new
  function automatic void regen_store();
    logic [127:0] a, b, r, c, d, b_sh, d_sh;
    int           i, k;
    c = twist_store[VECTORS - 2];
    d = twist_store[VECTORS - 1];
    for (i = 0; i < VECTORS; i++) begin
      a = twist_store[i];
      b = twist_store[(i + PICK_OFFSET) % VECTORS];
      for (k = 0; k < 4; k++) begin
        b_sh[32 * k +: 32] = b[32 * k +: 32] >> 1;
        d_sh[32 * k +: 32] = d[32 * k +: 32] << WORD_LEFT_SHIFT;
      end
      r = a ^ (a << VEC_SHIFT) ^ (b_sh & MIX_MASK) ^ (c >> VEC_SHIFT) ^ d_sh;
      twist_store[i] = r;
      c = d;
      d = r;
    end
  endfunction

  function automatic logic [31:0] next_word();
    if (word_idx >= TOTAL_WORDS) begin
      regen_store();
      word_idx    = 0;
      regen_count = regen_count + 1;
    end
    next_word = twist_store[word_idx / 4][32 * (word_idx % 4) +: 32];
    word_idx  = word_idx + 1;
  endfunction

  // ------------------------------------------------------------------
  // channel drivers
  // ------------------------------------------------------------------

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
      IDLE_SEND: begin tx_gap_pct = 50; rx_stall_pct = 0;  end
      IDLE_RECV: begin tx_gap_pct = 0;  rx_stall_pct = 50; end
      default:   begin tx_gap_pct = 33; rx_stall_pct = 33; end
    endcase
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic op, input logic [31:0] seed);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_gap_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.seed  <= seed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // item accepted at this edge
    items_sent = items_sent + 1;
    if (op == OP_SEED) begin
      load_seed(seed);
      seeds_sent = seeds_sent + 1;
    end else begin
      pending_words.push_back(next_word());
    end
    @(negedge clk);
  endtask

  // sender goes quiet until every owed word is out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: long hold first, else random stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left = rx_hold_left - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // output checker
  always @(posedge clk) begin : check_words
    logic [31:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("random_word: expected nothing, actual %h", out_ch.random_word);
        fail_count = fail_count + 1;
      end else begin
        want = pending_words.pop_front();
        words_checked = words_checked + 1;
        if (out_ch.random_word !== want) begin
          $error("random_word: expected %h, actual %h", want, out_ch.random_word);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // unseeded store read through its end, so the read index wraps too
  task automatic test_unseeded_reads();
    int n;
    set_idle(IDLE_BOTH);
    send_item(OP_NEXT, 32'h0000_0000);
    send_item(OP_NEXT, 32'hffff_ffff);
    for (n = 0; n < TOTAL_WORDS; n++) send_item(OP_NEXT, $urandom);
  endtask

  // seed extremes, alternating patterns, reseed before any read
  task automatic test_seed_extremes();
    set_idle(IDLE_NONE);
    send_item(OP_SEED, 32'h0000_0000);
    repeat (3) send_item(OP_NEXT, $urandom);
    send_item(OP_SEED, 32'hffff_ffff);
    send_item(OP_NEXT, 32'h0000_0000);
    send_item(OP_NEXT, 32'hffff_ffff);
    send_item(OP_NEXT, $urandom);
    send_item(OP_SEED, 32'haaaa_aaaa);
    send_item(OP_SEED, 32'h5555_5555);
    repeat (3) send_item(OP_NEXT, $urandom);
    send_item(OP_SEED, 32'h0000_0001);
    repeat (2) send_item(OP_NEXT, $urandom);
    send_item(OP_SEED, 32'h8000_0000);
    repeat (2) send_item(OP_NEXT, $urandom);
  endtask

  // output held off, but the hold runs out while the seed fill still busies the block
  task automatic test_backpressure();
    set_idle(IDLE_NONE);
    send_item(OP_SEED, $urandom);
    rx_hold_left = 300;
    repeat (40) send_item(OP_NEXT, $urandom);
    wait_drained();
  endtask

  // seed followed by a run of reads; each run opens with a regeneration
  task automatic test_random_stream(input int total);
    int sent;
    int run_left;
    sent     = 0;
    run_left = 0;
    while (sent < total) begin
      set_idle(idle_mode_t'((sent * 4) / total));
      if (run_left == 0) begin
        send_item(OP_SEED, $urandom);
        if (sent == 0) begin
          run_left = $urandom_range(120, 180);
        end else if ($urandom_range(9) == 0) begin
          run_left = $urandom_range(100, 300);
        end else begin
          run_left = $urandom_range(1, 60);
        end
      end else if (sent > 20 && $urandom_range(49) == 0) begin
        // broken run: reseed in the middle
        send_item(OP_SEED, $urandom);
      end else begin
        send_item(OP_NEXT, $urandom);
        run_left = run_left - 1;
      end
      sent = sent + 1;
    end
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin
    int v;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_SEED;
    in_ch.seed    = 32'h0;
    rst_n         = 1'b0;
    fail_count    = 0;
    items_sent    = 0;
    seeds_sent    = 0;
    words_checked = 0;
    regen_count   = 0;
    rx_hold_left  = 0;
    tx_gap_pct    = 0;
    rx_stall_pct  = 0;
    word_idx      = 0;
    for (v = 0; v < VECTORS; v++) twist_store[v] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unseeded_reads();
    test_seed_extremes();
    test_backpressure();
    test_random_stream(216);

    // drain, then allow for a trailing seed fill
    wait_drained();
    set_idle(IDLE_NONE);
    repeat (SEED_CYCLES + 50) @(negedge clk);

    if (pending_words.size() != 0) begin
      $error("random_word: %0d expected words never arrived", pending_words.size());
      fail_count = fail_count + 1;
    end

    $display("covered %0d items (%0d seeds), %0d words checked, %0d regenerations",
             items_sent, seeds_sent, words_checked, regen_count);
    $display("phases: unseeded reads, seed extremes, long back-pressure, random runs");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
